// ===== rtl/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, codes and the CRC-16 byte update for the RTU frame CRC block.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int unsigned CAP_W     = 9;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned CFG_W     = 9;

  localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY  = 1'b1;

  localparam logic MODE_TX = 1'b0;
  localparam logic MODE_RX = 1'b1;

  localparam logic [15:0]      CRC_PRESET    = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY      = 16'hA001;
  localparam logic [CAP_W-1:0] CAPACITY_RST  = 9'd256;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_SHORT   = 2'd2,
    ST_LONG    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_ECHO   = 2'd0,
    CMD_TX_END = 2'd1,
    CMD_RX_END = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    status_t     status;
    logic [15:0] crc_value;
  } out_beat_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [15:0] crc;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/rfc_front.sv =====
// ----------------------------------------------------------------------------
// rfc_front
// Takes frame bytes, runs the CRC, count and hold line, and issues commands.
// ----------------------------------------------------------------------------
module rfc_front #(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  rfc_pkg::in_beat_t     in_data,
  output logic                  in_full,
  input  logic                  cfg_mode,
  input  logic [rfc_pkg::CAP_W-1:0] cfg_capacity,
  input  logic                  fifo_full,
  output logic                  cmd_push,
  output rfc_pkg::cmd_t         cmd
);
  import rfc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       held_r [2];
  logic [7:0]       held_nxt [2];
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             accept;
  logic [CNT_W-1:0] count_inc;
  logic [15:0]      crc_tx, crc_rx;
  logic [CMP_W-1:0] cap_ext, max_ext, cap_eff;
  logic             too_long;
  logic [15:0]      recv_crc;

  assign accept    = in_push && !fifo_full;
  assign in_full   = fifo_full;
  assign count_inc = (count_r < CNT_W'(MAX_FRAME)) ? count_r + CNT_W'(1) : CNT_W'(MAX_FRAME);

  assign crc_tx = crc16_byte(crc_r, in_data.data_byte);
  assign crc_rx = (count_r >= CNT_W'(2)) ? crc16_byte(crc_r, held_r[0]) : crc_r;

  assign cap_ext  = CMP_W'(cfg_capacity);
  assign max_ext  = CMP_W'(MAX_FRAME);
  assign cap_eff  = (cap_ext < max_ext) ? cap_ext : max_ext;
  assign too_long = (CMP_W'(count_inc) + CMP_W'(2)) > cap_eff;
  assign recv_crc = {in_data.data_byte, held_r[1]};

  always_comb begin
    crc_nxt     = crc_r;
    held_nxt[0] = held_r[0];
    held_nxt[1] = held_r[1];
    count_nxt   = count_r;
    cmd_push    = 1'b0;
    cmd.kind      = CMD_ECHO;
    cmd.data_byte = in_data.data_byte;
    cmd.status    = ST_OK;
    cmd.crc       = 16'h0000;
    if (accept) begin
      count_nxt = count_inc;
      if (cfg_mode == MODE_TX) begin
        crc_nxt  = crc_tx;
        cmd_push = 1'b1;
        if (in_data.in_last) begin
          cmd.kind   = CMD_TX_END;
          cmd.status = too_long ? ST_LONG : ST_OK;
          cmd.crc    = crc_tx;
        end
      end else begin
        crc_nxt     = crc_rx;
        held_nxt[0] = held_r[1];
        held_nxt[1] = in_data.data_byte;
        if (in_data.in_last) begin
          cmd_push      = 1'b1;
          cmd.kind      = CMD_RX_END;
          cmd.data_byte = 8'h00;
          cmd.crc       = crc_rx;
          if (count_inc < CNT_W'(4)) begin
            cmd.status = ST_SHORT;
          end else begin
            cmd.status = (crc_rx == recv_crc) ? ST_OK : ST_CRC_ERR;
          end
        end
      end
      if (in_data.in_last) begin
        crc_nxt     = CRC_PRESET;
        held_nxt[0] = 8'h00;
        held_nxt[1] = 8'h00;
        count_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= CRC_PRESET;
      held_r[0] <= 8'h00;
      held_r[1] <= 8'h00;
      count_r   <= '0;
    end else begin
      crc_r     <= crc_nxt;
      held_r[0] <= held_nxt[0];
      held_r[1] <= held_nxt[1];
      count_r   <= count_nxt;
    end
  end

endmodule

// ===== rtl/rfc_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// rfc_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module rfc_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rfc_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output rfc_pkg::cmd_t rd_cmd,
  output logic          empty
);
  import rfc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/rfc_back.sv =====
// ----------------------------------------------------------------------------
// rfc_back
// Expands commands into result beats behind a one-beat output register.
// ----------------------------------------------------------------------------
module rfc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rfc_pkg::cmd_t       cmd,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  output rfc_pkg::out_beat_t  out_data,
  output logic                out_empty,
  input  logic                out_pop
);
  import rfc_pkg::*;

  typedef enum logic [1:0] {
    PH_BYTE,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  phase_t    phase_r, phase_nxt;
  logic      out_valid_r;
  out_beat_t out_data_r;
  out_beat_t beat;
  logic      load, final_beat;

  assign load      = cmd_valid && (!out_valid_r || out_pop);
  assign cmd_pop   = load && final_beat;
  assign out_data  = out_data_r;
  assign out_empty = !out_valid_r;

  always_comb begin
    beat.out_byte  = cmd.data_byte;
    beat.out_last  = 1'b0;
    beat.status    = ST_OK;
    beat.crc_value = 16'h0000;
    final_beat     = 1'b1;
    phase_nxt      = PH_BYTE;
    unique case (cmd.kind)
      CMD_ECHO: ;
      CMD_TX_END: begin
        unique case (phase_r)
          PH_BYTE: begin
            final_beat = 1'b0;
            phase_nxt  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            beat.out_byte = cmd.crc[7:0];
            final_beat    = 1'b0;
            phase_nxt     = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            beat.out_byte  = cmd.crc[15:8];
            beat.out_last  = 1'b1;
            beat.status    = cmd.status;
            beat.crc_value = cmd.crc;
          end
          default: ;
        endcase
      end
      CMD_RX_END: begin
        beat.out_byte  = 8'h00;
        beat.out_last  = 1'b1;
        beat.status    = cmd.status;
        beat.crc_value = cmd.crc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_BYTE;
    end else if (load) begin
      out_valid_r <= 1'b1;
      out_data_r  <= beat;
      phase_r     <= phase_nxt;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/rtu_frame_crc_append_check_core.sv =====
// ----------------------------------------------------------------------------
// rtu_frame_crc_append_check_core
// Modbus RTU CRC-16 framing: appends the CRC on transmit, checks it on receive.
// ----------------------------------------------------------------------------
//  channel  ports                          beat
//  input    in_push / in_full / in_data    one frame byte plus last marker
//  result   out_pop / out_empty / out_data echoed byte, CRC byte or rx status
//  config   cfg_we / cfg_addr / cfg_wdata  0 direction_mode, 1 frame_capacity
//
//  One input byte per cycle while in_full is low; the CRC byte update is combinational in the front.
//  A transmit frame end gives three result beats, so the result side is busy
//  longer for that byte; the command queue (CMD_DEPTH) absorbs it.
//  Receive bytes other than the last give no beat.
//  Synchronous reset; a full queue raises in_full, an unread result holds.
// ----------------------------------------------------------------------------
module rtu_frame_crc_append_check_core #(
  parameter int unsigned MAX_FRAME = 256,
  parameter int unsigned CMD_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  rfc_pkg::in_beat_t               in_data,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output rfc_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [rfc_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [rfc_pkg::CFG_W-1:0]       cfg_wdata
);
  import rfc_pkg::*;

  logic             mode_r;
  logic [CAP_W-1:0] capacity_r;

  logic fifo_full, fifo_empty, cmd_push, cmd_pop;
  cmd_t cmd_wr, cmd_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_TX;
      capacity_r <= CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DIRECTION: mode_r     <= cfg_wdata[0];
        REG_CAPACITY:  capacity_r <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  rfc_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data      (in_data),
    .in_full      (in_full),
    .cfg_mode     (mode_r),
    .cfg_capacity (capacity_r),
    .fifo_full    (fifo_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_wr)
  );

  rfc_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd_wr),
    .full   (fifo_full),
    .pop    (cmd_pop),
    .rd_cmd (cmd_rd),
    .empty  (fifo_empty)
  );

  rfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_rd),
    .cmd_valid (!fifo_empty),
    .cmd_pop   (cmd_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// ===== rtl/rfc_checker.sv =====
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks for the RTU frame CRC block, bound to the top level.
// ----------------------------------------------------------------------------
module rfc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input rfc_pkg::out_beat_t out_data
);
  import rfc_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("stalled result beat changed");

  a_mid_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_data.out_last |-> out_data.status == ST_OK &&
                                         out_data.crc_value == 16'h0000)
    else $error("status or crc on a non-final beat");

  a_short_is_rx: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.status == ST_SHORT || out_data.status == ST_CRC_ERR)
      |-> out_data.out_last && out_data.out_byte == 8'h00)
    else $error("receive status beat malformed");

endmodule

bind rtu_frame_crc_append_check_core rfc_checker u_rfc_checker (.*);
